>>> hdl/fslm_pkg.sv
// Shared types, constants and helpers for the fixed-string line matcher.
package fslm_pkg;

    localparam int PATTERN_MAX_DEF   = 32;
    localparam int OFFSET_BITS_DEF   = 32;
    localparam int BINARY_WINDOW_DEF = 65536;

    localparam int PAT_BYTES = 32;
    localparam int PAT_WORDS = 4;
    localparam int PAT_IDX_W = 5;
    localparam int PLEN_CFG_W = 6;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_INSENSITIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD3    = 3'd5;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] NUL_BYTE     = 8'h00;

    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = 2;
    localparam int RES_COUNT_W = 3;

    typedef struct packed {
        logic        kind;
        logic [31:0] line_start;
        logic [31:0] line_length;
        logic        binary_file;
        logic        any_match;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic [RES_COUNT_W-1:0] count;
        logic                   full;
    } t_fifo_status;

    function automatic logic [7:0] fold_byte(input logic fold_en, input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> hdl/fixed_string_line_matcher.sv
// Top level of the fixed-string line matcher.
//
// Input channel: one file byte per request (i_data_byte, i_end_of_file on the
// final byte), taken when i_in_valid is high and o_in_stall is low.
// Output channel: result requests (matched line or end-of-file summary),
// taken when o_out_valid is high and i_out_stall is low.
// Config channel: i_cfg_valid with o_cfg_ready (always high), register
// index and 64-bit data; write only while the block is idle.
// Each byte is matched against the pattern in the cycle it is taken, in a
// parallel compare over the whole byte window; its results are registered
// into the queue. Throughput is one byte per cycle while o_in_stall is low.
// A byte may cause two results (last line and summary); these sit in a
// four-entry result queue. o_in_stall rises when the queue has fewer than
// two free entries, so with the receiver stalled the input is held off once
// three results are waiting, while those results are held unchanged.
// Reset clears the configuration, the queue and the per-file state but for
// the byte window. After each summary that state returns to its reset value.
module fixed_string_line_matcher #(
    parameter int PATTERN_MAX   = fslm_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS   = fslm_pkg::OFFSET_BITS_DEF,
    parameter int BINARY_WINDOW = fslm_pkg::BINARY_WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_end_of_file,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_kind,
    output logic [31:0]                    o_line_start,
    output logic [31:0]                    o_line_length,
    output logic                           o_binary_file,
    output logic                           o_any_match,
    output logic                           o_last_of_run,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fslm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);
    import fslm_pkg::*;

    localparam int PLEN_W = $clog2(PATTERN_MAX + 1);

    // configuration
    logic                   r_case_insensitive;
    logic [PLEN_CFG_W-1:0]  r_pattern_length;
    logic [63:0]            r_pattern_word [PAT_WORDS];

    // per-file state
    logic [7:0]             r_window [PATTERN_MAX];
    logic [PLEN_W-1:0]      r_fill, n_fill;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [OFFSET_BITS-1:0] r_line_start, n_line_start;
    logic                   r_line_match, n_line_match;
    logic                   r_binary, n_binary;
    logic                   r_file_match, n_file_match;

    logic                   in_accept;
    logic                   is_newline;
    logic [7:0]             folded;
    logic [PLEN_W-1:0]      plen;
    logic                   empty_pat;
    logic [PAT_BYTES*8-1:0] pat_flat;
    logic [7:0]             win_next [PATTERN_MAX];
    logic [PLEN_W-1:0]      fill_inc;
    logic [PATTERN_MAX-1:0] hit;
    logic                   window_match;
    logic [OFFSET_BITS-1:0] off_next;
    logic [OFFSET_BITS-1:0] line_len;
    logic                   line_emit;
    t_result                line_res;
    t_result                sum_res;
    t_push                  push;
    t_result                head;
    t_fifo_status           fifo_status;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = fifo_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_insensitive <= 1'b0;
            r_pattern_length   <= '0;
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pattern_word[w] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CASE_INSENSITIVE: r_case_insensitive <= i_cfg_data[0];
                CFG_PATTERN_LENGTH:   r_pattern_length <= i_cfg_data[PLEN_CFG_W-1:0];
                CFG_PATTERN_WORD0:    r_pattern_word[0] <= i_cfg_data;
                CFG_PATTERN_WORD1:    r_pattern_word[1] <= i_cfg_data;
                CFG_PATTERN_WORD2:    r_pattern_word[2] <= i_cfg_data;
                CFG_PATTERN_WORD3:    r_pattern_word[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // match logic
    always_comb begin
        for (int w = 0; w < PAT_WORDS; w++) begin
            pat_flat[w*64 +: 64] = r_pattern_word[w];
        end
        if (r_pattern_length > PLEN_CFG_W'(PATTERN_MAX)) begin
            plen = PLEN_W'(PATTERN_MAX);
        end else begin
            plen = PLEN_W'(r_pattern_length);
        end
        empty_pat  = plen == '0;
        folded     = fold_byte(r_case_insensitive, i_data_byte);
        is_newline = i_data_byte == NEWLINE_BYTE;
        win_next[0] = folded;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            win_next[j] = r_window[j-1];
        end
        if (r_fill == PLEN_W'(PATTERN_MAX)) begin
            fill_inc = r_fill;
        end else begin
            fill_inc = r_fill + 1'b1;
        end
        // window slot j holds the byte that pattern byte plen-1-j must equal
        for (int j = 0; j < PATTERN_MAX; j++) begin
            logic [PAT_IDX_W-1:0] idx;
            idx = PAT_IDX_W'(PLEN_CFG_W'(plen) - PLEN_CFG_W'(j) - PLEN_CFG_W'(1));
            hit[j] = (PLEN_W'(j) >= plen) ||
                     (win_next[j] == fold_byte(r_case_insensitive, pat_flat[idx*8 +: 8]));
        end
        window_match = !empty_pat && (fill_inc >= plen) && (&hit);
    end

    // per-byte state and results
    always_comb begin
        off_next = (r_offset == '1) ? r_offset
                                    : r_offset + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
        n_binary = r_binary ||
                   (i_data_byte == NUL_BYTE && 64'(r_offset) < 64'(BINARY_WINDOW));
        n_fill       = fill_inc;
        n_offset     = off_next;
        n_line_start = r_line_start;
        n_line_match = r_line_match;
        n_file_match = r_file_match;
        line_len     = off_next - r_line_start;
        line_emit    = 1'b0;
        if (is_newline) begin
            line_emit    = !n_binary && (r_line_match || empty_pat);
            line_len     = r_offset - r_line_start;
            n_line_match = 1'b0;
            n_line_start = off_next;
            n_fill       = '0;
        end else begin
            n_line_match = r_line_match || window_match;
            line_emit    = i_end_of_file && !n_binary && (n_line_match || empty_pat);
        end
        if (line_emit) begin
            n_file_match = 1'b1;
        end

        line_res.kind        = KIND_LINE;
        line_res.line_start  = 32'(r_line_start);
        line_res.line_length = 32'(line_len);
        line_res.binary_file = 1'b0;
        line_res.any_match   = 1'b0;
        line_res.last_of_run = !i_end_of_file;

        sum_res.kind        = KIND_SUMMARY;
        sum_res.line_start  = '0;
        sum_res.line_length = '0;
        sum_res.binary_file = n_binary;
        sum_res.any_match   = n_file_match && !n_binary;
        sum_res.last_of_run = 1'b1;

        push.count  = 2'd0;
        push.first  = line_res;
        push.second = sum_res;
        if (in_accept) begin
            if (line_emit && i_end_of_file) begin
                push.count = 2'd2;
            end else if (line_emit) begin
                push.count = 2'd1;
            end else if (i_end_of_file) begin
                push.count = 2'd1;
                push.first = sum_res;
            end
        end

        if (i_end_of_file) begin
            n_offset     = '0;
            n_line_start = '0;
            n_line_match = 1'b0;
            n_binary     = 1'b0;
            n_file_match = 1'b0;
            n_fill       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_offset     <= '0;
            r_line_start <= '0;
            r_line_match <= 1'b0;
            r_binary     <= 1'b0;
            r_file_match <= 1'b0;
        end else if (in_accept) begin
            r_fill       <= n_fill;
            r_offset     <= n_offset;
            r_line_start <= n_line_start;
            r_line_match <= n_line_match;
            r_binary     <= n_binary;
            r_file_match <= n_file_match;
        end
    end

    // slots beyond the fill count are never compared, so no clearing needed
    always_ff @(posedge i_clk) begin
        if (in_accept && !is_newline) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_window[j] <= win_next[j];
            end
        end
    end

    fslm_result_fifo u_result_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (!i_out_stall),
        .o_head   (head),
        .o_valid  (o_out_valid),
        .o_status (fifo_status)
    );

    assign o_kind        = head.kind;
    assign o_line_start  = head.line_start;
    assign o_line_length = head.line_length;
    assign o_binary_file = head.binary_file;
    assign o_any_match   = head.any_match;
    assign o_last_of_run = head.last_of_run;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_status.count <= RES_COUNT_W'(RES_DEPTH))
        else $error("result queue overrun");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_SUMMARY) |->
            (o_line_start == '0 && o_line_length == '0 && o_last_of_run))
        else $error("summary request carries line fields");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_end_of_file) |=>
            (r_offset == '0 && r_fill == '0 && !r_binary && !r_file_match))
        else $error("file state not cleared after end of file");

    a_newline_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_newline) |=> (r_fill == '0 && !r_line_match))
        else $error("line state not cleared after newline");

endmodule

>>> hdl/fslm_result_fifo.sv
// Small result queue: up to two pushes per cycle, one pop per cycle with i_pop.
module fslm_result_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fslm_pkg::t_push       i_push,
    input  logic                  i_pop,
    output fslm_pkg::t_result     o_head,
    output logic                  o_valid,
    output fslm_pkg::t_fifo_status o_status
);
    import fslm_pkg::*;

    t_result                r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [RES_COUNT_W-1:0] r_count, n_count;
    logic                   pop_ok;

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    // free slots for two more requests are needed before the next byte
    assign o_status.count = r_count;
    assign o_status.full  = r_count > RES_COUNT_W'(RES_DEPTH - 2);

    always_comb begin
        n_wr_ptr = r_wr_ptr + RES_PTR_W'(i_push.count);
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + RES_COUNT_W'(i_push.count) - RES_COUNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + 1'b1] <= i_push.second;
        end
    end

endmodule

>>> test/fixed_string_line_matcher_checker.sv
// Checker for the fixed-string line matcher: watches the channels, predicts every report and compares them.
`timescale 1ns / 100ps

module fixed_string_line_matcher_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_end_of_file,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic                           o_kind,
    input  logic [31:0]                    o_line_start,
    input  logic [31:0]                    o_line_length,
    input  logic                           o_binary_file,
    input  logic                           o_any_match,
    input  logic                           o_last_of_run,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [fslm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    output int                             o_error_count,
    output int                             o_results_pending
);

    import fslm_pkg::*;

    localparam int          WINDOW     = PATTERN_MAX_DEF;
    localparam logic [31:0] OFFSET_TOP = 32'hFFFF_FFFF;

    // register copies
    logic        fold_upper;
    logic [5:0]  pat_len_reg;
    logic [63:0] pat_words [PAT_WORDS];

    // per-file state
    logic [7:0]  tail [WINDOW];
    int          tail_fill;
    logic [31:0] byte_pos;
    logic [31:0] line_origin;
    logic        line_hit;
    logic        nul_seen;
    logic        file_hit;

    t_result     reports_due [$];

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (fold_upper && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic int live_length();
        return (pat_len_reg > WINDOW) ? WINDOW : int'(pat_len_reg);
    endfunction

    function automatic logic tail_holds_pattern();
        int plen;
        plen = live_length();
        if (plen == 0 || tail_fill < plen) begin
            return 1'b0;
        end
        for (int k = 0; k < plen; k++) begin
            if (tail[plen - 1 - k] != to_lower(pat_words[k / 8][(k % 8) * 8 +: 8])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_result make_report(input logic kind, input logic [31:0] start,
                                            input logic [31:0] len, input logic bin,
                                            input logic any);
        t_result r;
        r.kind        = kind;
        r.line_start  = start;
        r.line_length = len;
        r.binary_file = bin;
        r.any_match   = any;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    task automatic start_new_file();
        for (int i = 0; i < WINDOW; i++) begin
            tail[i] = 8'h00;
        end
        tail_fill   = 0;
        byte_pos    = '0;
        line_origin = '0;
        line_hit    = 1'b0;
        nul_seen    = 1'b0;
        file_hit    = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic eof);
        t_result     made [$];
        logic [31:0] here;
        logic [31:0] after;
        logic        no_pattern;
        here       = byte_pos;
        after      = (here == OFFSET_TOP) ? here : here + 32'd1;
        no_pattern = (live_length() == 0);
        if (b == NUL_BYTE && here < BINARY_WINDOW_DEF) begin
            nul_seen = 1'b1;
        end
        if (b == NEWLINE_BYTE) begin
            if (!nul_seen && (line_hit || no_pattern)) begin
                made.push_back(make_report(KIND_LINE, line_origin, here - line_origin,
                                           1'b0, 1'b0));
                file_hit = 1'b1;
            end
            for (int i = 0; i < WINDOW; i++) begin
                tail[i] = 8'h00;
            end
            tail_fill   = 0;
            line_hit    = 1'b0;
            line_origin = after;
        end else begin
            for (int i = WINDOW - 1; i > 0; i--) begin
                tail[i] = tail[i - 1];
            end
            tail[0] = to_lower(b);
            if (tail_fill < WINDOW) begin
                tail_fill++;
            end
            if (tail_holds_pattern()) begin
                line_hit = 1'b1;
            end
            // unterminated final line
            if (eof && !nul_seen && (line_hit || no_pattern)) begin
                made.push_back(make_report(KIND_LINE, line_origin, after - line_origin,
                                           1'b0, 1'b0));
                file_hit = 1'b1;
            end
        end
        byte_pos = after;
        if (eof) begin
            made.push_back(make_report(KIND_SUMMARY, '0, '0, nul_seen, file_hit && !nul_seen));
            start_new_file();
        end
        if (made.size() > 0) begin
            made[made.size() - 1].last_of_run = 1'b1;
        end
        foreach (made[i]) begin
            reports_due.push_back(made[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_error_count++;
        end
    endtask

    initial begin
        o_error_count     = 0;
        o_results_pending = 0;
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            fold_upper  = 1'b0;
            pat_len_reg = '0;
            for (int w = 0; w < PAT_WORDS; w++) begin
                pat_words[w] = '0;
            end
            start_new_file();
            reports_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CASE_INSENSITIVE: fold_upper   = i_cfg_data[0];
                    CFG_PATTERN_LENGTH:   pat_len_reg  = i_cfg_data[5:0];
                    CFG_PATTERN_WORD0:    pat_words[0] = i_cfg_data;
                    CFG_PATTERN_WORD1:    pat_words[1] = i_cfg_data;
                    CFG_PATTERN_WORD2:    pat_words[2] = i_cfg_data;
                    CFG_PATTERN_WORD3:    pat_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                scan_byte(i_data_byte, i_end_of_file);
            end
            if (o_out_valid && !i_out_stall) begin
                if (reports_due.size() == 0) begin
                    $error("unexpected result request: kind %0d, start %0d, length %0d",
                           o_kind, o_line_start, o_line_length);
                    o_error_count++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("line_start", want.line_start, o_line_start);
                    check_field("line_length", want.line_length, o_line_length);
                    check_field("binary_file", want.binary_file, o_binary_file);
                    check_field("any_match", want.any_match, o_any_match);
                    check_field("last_of_run", want.last_of_run, o_last_of_run);
                end
            end
        end
        o_results_pending = reports_due.size();
    end

endmodule

>>> test/fixed_string_line_matcher_test.sv
// Testbench top for the fixed-string line matcher: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module fixed_string_line_matcher_test;

    import fslm_pkg::*;

    localparam int ITEM_TARGET   = 1850;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_data_byte;
    logic                 i_end_of_file;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_kind;
    logic [31:0]          o_line_start;
    logic [31:0]          o_line_length;
    logic                 o_binary_file;
    logic                 o_any_match;
    logic                 o_last_of_run;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;

    int                   error_count;
    int                   results_pending;

    logic [7:0]           pat [PAT_BYTES];
    int                   burst_left;
    int                   bytes_sent;
    logic                 hold_go;

    wire any_accept = (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                      (i_cfg_valid && o_cfg_ready);

    fixed_string_line_matcher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_line_start  (o_line_start),
        .o_line_length (o_line_length),
        .o_binary_file (o_binary_file),
        .o_any_match   (o_any_match),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    fixed_string_line_matcher_checker line_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_file     (i_end_of_file),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_line_start      (o_line_start),
        .o_line_length     (o_line_length),
        .o_binary_file     (o_binary_file),
        .o_any_match       (o_any_match),
        .o_last_of_run     (o_last_of_run),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_error_count     (error_count),
        .o_results_pending (results_pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] letter();
        case ($urandom_range(0, 3))
            0:       return "a";
            1:       return "b";
            2:       return "A";
            default: return "B";
        endcase
    endfunction

    function automatic logic [7:0] filler();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 6) != 0 || c == NEWLINE_BYTE) begin
            c = letter();
        end
        return c;
    endfunction

    // one byte request; valid stays high within a burst
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_in_valid    = 1'b1;
        i_data_byte   = b;
        i_end_of_file = eof;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic eof_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], eof_last && i == s.len() - 1);
        end
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_pattern(input logic ci, input logic [5:0] plen);
        logic [63:0] word;
        write_reg(CFG_CASE_INSENSITIVE, 64'(ci));
        write_reg(CFG_PATTERN_LENGTH, 64'(plen));
        for (int w = 0; w < PAT_WORDS; w++) begin
            for (int k = 0; k < 8; k++) begin
                word[8 * k +: 8] = pat[8 * w + k];
            end
            write_reg(CFG_PATTERN_WORD0 + CFG_IDX_W'(w), word);
        end
        i_cfg_valid = 1'b0;
    endtask

    initial begin : receiver
        int seg_left;
        int mode;
        int hold_left;
        bit hold_done;
        i_out_stall = 1'b0;
        seg_left    = 0;
        mode        = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 3) == 0);
                    2:       i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = ~i_out_stall;
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (any_accept) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] fbytes [$];
        logic [7:0] c;
        logic       ci;
        logic [5:0] plen;
        int         sel;
        int         word_kind;
        int         eff;
        int         nlines;
        int         len;
        int         at;
        int         n;
        int         k;
        int         j;
        int         w;
        int         ln;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = 8'h00;
        i_end_of_file = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_CASE_INSENSITIVE;
        i_cfg_data    = '0;
        hold_go       = 1'b0;
        burst_left    = 0;
        bytes_sent    = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty pattern at reset: every line reported, eof on a final newline
        send_text("a\n\nb\n", 1'b1);

        // case folding, no match across a newline, top byte value
        settle();
        for (k = 0; k < PAT_BYTES; k++) begin
            pat[k] = 8'hFF;
        end
        pat[0] = "a";
        pat[1] = "B";
        pat[2] = "c";
        load_pattern(1'b1, 6'd3);
        send_text("xABC\nab\nc", 1'b0);
        send_byte(8'hFF, 1'b1);

        // NUL after a matched line makes the file binary
        settle();
        pat[0] = "z";
        load_pattern(1'b0, 6'd1);
        send_text("z\n", 1'b0);
        send_byte(NUL_BYTE, 1'b0);
        send_byte("z", 1'b1);

        // folding switched on part way through a file
        send_text("Zq", 1'b0);
        settle();
        load_pattern(1'b1, 6'd1);
        send_text("Z", 1'b1);

        while (bytes_sent < ITEM_TARGET) begin
            settle();
            ci = $urandom_range(0, 1);
            for (k = 0; k < PAT_BYTES; k++) begin
                pat[k] = letter();
            end
            sel = $urandom_range(0, 9);
            case (sel)
                0: plen = 6'd0;
                1: plen = 6'd32;
                2: plen = ($urandom_range(0, 1) == 1) ? 6'd63 : 6'($urandom_range(33, 62));
                3: begin
                    // newline inside the pattern
                    plen = 6'($urandom_range(2, 4));
                    pat[$urandom_range(0, plen - 1)] = NEWLINE_BYTE;
                end
                4: begin
                    plen = 6'($urandom_range(0, 63));
                    for (w = 0; w < PAT_WORDS; w++) begin
                        word_kind = $urandom_range(0, 2);
                        for (j = 0; j < 8; j++) begin
                            pat[8 * w + j] = (word_kind == 0) ? 8'h00 :
                                             (word_kind == 1) ? 8'hFF :
                                             8'($urandom_range(0, 255));
                        end
                    end
                end
                default: plen = 6'($urandom_range(1, 4));
            endcase
            eff = (plen > PAT_BYTES) ? PAT_BYTES : int'(plen);
            load_pattern(ci, plen);
            hold_go = 1'b1;

            repeat ($urandom_range(1, 3)) begin
                fbytes.delete();
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(1, 40);
                    repeat (n) fbytes.push_back(8'($urandom_range(0, 255)));
                end else begin
                    nlines = $urandom_range(1, 6);
                    for (ln = 0; ln < nlines; ln++) begin
                        len = $urandom_range(0, 12);
                        at  = ($urandom_range(0, 9) < 4) ? int'($urandom_range(0, len)) : -1;
                        for (k = 0; k <= len; k++) begin
                            if (k == at) begin
                                for (j = 0; j < eff; j++) begin
                                    c = pat[j];
                                    if (ci && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                                        && $urandom_range(0, 1) == 1) begin
                                        c = c ^ 8'h20;
                                    end
                                    fbytes.push_back(c);
                                end
                            end
                            if (k < len) begin
                                fbytes.push_back(filler());
                            end
                        end
                        if (ln < nlines - 1 || $urandom_range(0, 1) == 1) begin
                            fbytes.push_back(NEWLINE_BYTE);
                        end
                    end
                    if (fbytes.size() == 0) begin
                        fbytes.push_back(filler());
                    end
                    if ($urandom_range(0, 11) == 0) begin
                        fbytes.insert($urandom_range(0, fbytes.size() - 1), NUL_BYTE);
                    end
                end
                for (k = 0; k < fbytes.size(); k++) begin
                    send_byte(fbytes[k], k == fbytes.size() - 1);
                end
            end
        end

        i_in_valid = 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && results_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
